// ===== rtl/envc_pkg.sv =====
`default_nettype none
package envc_pkg;

  localparam int FrontStages = 11;
  localparam int DivSteps    = 64;
  localparam int BackStages  = 5;

  typedef enum logic [2:0] {
    REG_TEMP_TRIM,
    REG_PRESS_TRIM_A,
    REG_PRESS_TRIM_B,
    REG_PRESS_TRIM_C,
    REG_HUM_TRIM_A,
    REG_HUM_TRIM_B
  } reg_idx_t;

  typedef struct packed {
    logic [47:0] temp_trim;
    logic [63:0] press_trim_a;
    logic [63:0] press_trim_b;
    logic [15:0] press_trim_c;
    logic [47:0] hum_trim_a;
    logic [23:0] hum_trim_b;
  } trim_t;

  // one record carried down the front pipeline; each stage fills its fields
  typedef struct packed {
    logic [19:0] rp;
    logic [15:0] rh;
    logic [31:0] m1;
    logic [31:0] bb;
    logic [31:0] v1;
    logic [31:0] v2p;
    logic [31:0] tf;
    logic [31:0] tc;
    logic [31:0] h;
    logic [63:0] x1;
    logic [63:0] sq;
    logic [63:0] xp5;
    logic [63:0] xp2;
    logic [63:0] a6;
    logic [63:0] a3;
    logic [63:0] x2;
    logic [63:0] x1b;
    logic [63:0] n;
    logic [63:0] d;
    logic [63:0] dv;
    logic [31:0] lp;
    logic [31:0] hh6;
    logic [31:0] hh3;
    logic [31:0] left;
    logic [31:0] inner;
    logic [31:0] r;
    logic [31:0] right;
    logic [31:0] hp;
    logic [31:0] ss;
    logic [31:0] t;
    logic [16:0] hum;
  } front_t;

  typedef struct packed {
    logic [31:0] tc;
    logic [16:0] hum;
    logic        dz;
  } side_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] quo;
    logic [63:0] mb;
    logic        neg;
    side_t       side;
  } div_t;

  typedef struct packed {
    logic [63:0] q;
    side_t       side;
  } quot_t;

  function automatic logic [31:0] sx16_32(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sx8_32(logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

  function automatic logic [63:0] sx16_64(logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  // low 64 bits of a 64-bit word times a signed 16-bit trim
  function automatic logic [63:0] mul_s16(logic [63:0] a, logic [15:0] b);
    logic signed [79:0] p;
    p = $signed(a) * $signed(b);
    return p[63:0];
  endfunction

  // low 64 bits of a 64-bit word times an unsigned 16-bit trim
  function automatic logic [63:0] mul_u16(logic [63:0] a, logic [15:0] b);
    logic [79:0] p;
    p = a * b;
    return p[63:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/envc_in_if.sv =====
`default_nettype none
interface envc_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_temp;
  logic [19:0] raw_press;
  logic [15:0] raw_hum;

  modport source (output valid, output raw_temp, output raw_press, output raw_hum,
                  input ready);
  modport sink   (input valid, input raw_temp, input raw_press, input raw_hum,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/envc_out_if.sv =====
`default_nettype none
interface envc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] temp_centi;
  logic [31:0] press_q24_8;
  logic [16:0] hum_q22_10;
  logic        press_div_zero;

  modport source (output valid, output temp_centi, output press_q24_8,
                  output hum_q22_10, output press_div_zero, input ready);
  modport sink   (input valid, input temp_centi, input press_q24_8,
                  input hum_q22_10, input press_div_zero, output ready);
endinterface
`default_nettype wire

// ===== rtl/envc_front.sv =====
`default_nettype none
module envc_front import envc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        adv,
  input  wire logic        in_valid,
  input  wire logic [19:0] raw_temp,
  input  wire logic [19:0] raw_press,
  input  wire logic [15:0] raw_hum,
  input  wire trim_t       trim,
  output logic             out_valid,
  output front_t           out_data
);

  front_t st [1:FrontStages];
  front_t nx [1:FrontStages];
  logic [FrontStages:1] vld;

  always_comb begin
    logic [31:0] a32;
    logic [31:0] b32;
    logic [31:0] tmp;
    logic signed [65:0] sq66;
    logic signed [48:0] p5x;
    logic signed [48:0] p2x;
    logic [20:0] pp0;
    logic [63:0] diff;
    logic [31:0] hv;

    // temperature differences and first products
    a32 = {15'd0, raw_temp[19:3]} - {15'd0, trim.temp_trim[15:0], 1'b0};
    b32 = {16'd0, raw_temp[19:4]} - {16'd0, trim.temp_trim[15:0]};
    nx[1]    = '0;
    nx[1].rp = raw_press;
    nx[1].rh = raw_hum;
    nx[1].m1 = a32 * sx16_32(trim.temp_trim[31:16]);
    nx[1].bb = b32 * b32;

    nx[2]     = st[1];
    nx[2].v1  = 32'($signed(st[1].m1) >>> 11);
    tmp       = 32'($signed(st[1].bb) >>> 12);
    nx[2].v2p = tmp * sx16_32(trim.temp_trim[47:32]);

    nx[3]    = st[2];
    nx[3].tf = st[2].v1 + 32'($signed(st[2].v2p) >>> 14);

    nx[4]    = st[3];
    nx[4].tc = 32'($signed(st[3].tf * 32'd5 + 32'd128) >>> 8);
    nx[4].x1 = {{32{st[3].tf[31]}}, st[3].tf} - 64'd128000;
    nx[4].h  = st[3].tf - 32'd76800;

    // x1 fits 33 bits signed
    nx[5]     = st[4];
    sq66      = $signed(st[4].x1[32:0]) * $signed(st[4].x1[32:0]);
    nx[5].sq  = sq66[63:0];
    p5x       = $signed(st[4].x1[32:0]) * $signed(trim.press_trim_b[15:0]);
    p2x       = $signed(st[4].x1[32:0]) * $signed(trim.press_trim_a[31:16]);
    nx[5].xp5 = 64'(p5x);
    nx[5].xp2 = 64'(p2x);
    nx[5].lp  = {2'd0, st[4].rh, 14'd0} - {trim.hum_trim_a[43:32], 20'd0}
              - st[4].h * sx16_32(trim.hum_trim_b[15:0]) + 32'd16384;
    nx[5].hh6 = st[4].h * sx8_32(trim.hum_trim_b[23:16]);
    nx[5].hh3 = st[4].h * {24'd0, trim.hum_trim_a[31:24]};

    nx[6]       = st[5];
    nx[6].a6    = mul_s16(st[5].sq, trim.press_trim_b[31:16]);
    nx[6].left  = 32'($signed(st[5].lp) >>> 15);
    nx[6].inner = 32'($signed(st[5].hh6) >>> 10)
                * (32'($signed(st[5].hh3) >>> 11) + 32'd32768);

    nx[7]    = st[6];
    nx[7].a3 = mul_s16(st[6].sq, trim.press_trim_a[47:32]);
    nx[7].x2 = st[6].a6 + (st[6].xp5 << 17) + (sx16_64(trim.press_trim_a[63:48]) << 35);
    tmp      = 32'($signed(st[6].inner) >>> 10) + 32'd2097152;
    nx[7].r  = tmp * sx16_32(trim.hum_trim_a[23:8]) + 32'd8192;

    nx[8]       = st[7];
    nx[8].x1b   = 64'($signed(st[7].a3) >>> 8) + (st[7].xp2 << 12);
    pp0         = 21'd1048576 - {1'b0, st[7].rp};
    diff        = {12'd0, pp0, 31'd0} - st[7].x2;
    nx[8].n     = diff * 64'd3125;
    nx[8].right = 32'($signed(st[7].r) >>> 14);
    nx[8].hp    = st[7].left * nx[8].right;

    nx[9]    = st[8];
    nx[9].d  = mul_u16(64'h0000_8000_0000_0000 + st[8].x1b, trim.press_trim_a[15:0]);
    tmp      = 32'($signed(st[8].hp) >>> 15);
    nx[9].ss = tmp * tmp;

    nx[10]    = st[9];
    nx[10].dv = 64'($signed(st[9].d) >>> 33);
    nx[10].t  = 32'($signed(st[9].ss) >>> 7) * {24'd0, trim.hum_trim_a[7:0]};

    // humidity clamp to 0 .. 100 %RH before the final shift to Q22.10
    nx[11] = st[10];
    hv     = st[10].hp - 32'($signed(st[10].t) >>> 4);
    if (hv[31]) begin
      hv = '0;
    end else if (hv > 32'd419430400) begin
      hv = 32'd419430400;
    end
    nx[11].hum = hv[28:12];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[FrontStages-1:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 1; k <= FrontStages; k++) begin
        st[k] <= nx[k];
      end
    end
  end

  assign out_valid = vld[FrontStages];
  assign out_data  = st[FrontStages];

endmodule
`default_nettype wire

// ===== rtl/envc_div.sv =====
`default_nettype none
module envc_div import envc_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   adv,
  input  wire logic   in_valid,
  input  wire front_t in_data,
  output logic        out_valid,
  output quot_t       out_data
);

  div_t ds [0:DivSteps];
  div_t dn [0:DivSteps];
  logic [DivSteps+1:0] vld;
  quot_t fin;

  always_comb begin
    logic [64:0] tmp;
    // magnitudes and signs
    dn[0].rem      = '0;
    dn[0].quo      = in_data.n[63] ? 64'(-in_data.n) : in_data.n;
    dn[0].mb       = in_data.dv[63] ? 64'(-in_data.dv) : in_data.dv;
    dn[0].neg      = in_data.n[63] ^ in_data.dv[63];
    dn[0].side.tc  = in_data.tc;
    dn[0].side.hum = in_data.hum;
    dn[0].side.dz  = (in_data.dv == '0);
    // one restoring step per stage
    for (int k = 1; k <= DivSteps; k++) begin
      tmp       = {ds[k-1].rem, ds[k-1].quo[63]};
      dn[k]     = ds[k-1];
      dn[k].quo = {ds[k-1].quo[62:0], 1'b0};
      if (tmp >= {1'b0, ds[k-1].mb}) begin
        dn[k].rem    = 64'(tmp - {1'b0, ds[k-1].mb});
        dn[k].quo[0] = 1'b1;
      end else begin
        dn[k].rem = tmp[63:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DivSteps:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k <= DivSteps; k++) begin
        ds[k] <= dn[k];
      end
      fin.q    <= ds[DivSteps].neg ? 64'(-ds[DivSteps].quo) : ds[DivSteps].quo;
      fin.side <= ds[DivSteps].side;
    end
  end

  assign out_valid = vld[DivSteps+1];
  assign out_data  = fin;

endmodule
`default_nettype wire

// ===== rtl/envc_back.sv =====
`default_nettype none
module envc_back import envc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        adv,
  input  wire logic        in_valid,
  input  wire quot_t       in_data,
  input  wire trim_t       trim,
  output logic             out_valid,
  output logic [31:0]      temp_centi,
  output logic [31:0]      press_q24_8,
  output logic [16:0]      hum_q22_10,
  output logic             press_div_zero
);

  typedef struct packed {
    logic [63:0] pp;
    logic [63:0] qq;
    logic [63:0] ll;
    logic [31:0] hl;
    logic [63:0] qsq;
    logic [63:0] y2;
    logic [63:0] y1p;
    logic [31:0] press;
    side_t       side;
  } back_t;

  back_t sb [1:BackStages];
  back_t nb [1:BackStages];
  logic [BackStages:1] vld;

  always_comb begin
    logic [63:0] y1;
    logic [63:0] sum;
    nb[1]      = '0;
    nb[1].pp   = in_data.q;
    nb[1].side = in_data.side;
    nb[1].qq   = 64'($signed(in_data.q) >>> 13);
    nb[1].ll   = nb[1].qq[31:0] * nb[1].qq[31:0];

    nb[2]    = sb[1];
    nb[2].hl = sb[1].qq[63:32] * sb[1].qq[31:0];
    nb[2].y2 = 64'($signed(mul_s16(sb[1].pp, trim.press_trim_b[63:48])) >>> 19);

    // q*q mod 2^64 = lo*lo + 2*hi*lo*2^32
    nb[3]     = sb[2];
    nb[3].qsq = sb[2].ll + {sb[2].hl[30:0], 33'd0};

    nb[4]     = sb[3];
    nb[4].y1p = mul_s16(sb[3].qsq, trim.press_trim_c);

    nb[5] = sb[4];
    y1    = 64'($signed(sb[4].y1p) >>> 25);
    sum   = 64'($signed(sb[4].pp + y1 + sb[4].y2) >>> 8)
          + (sx16_64(trim.press_trim_b[47:32]) << 4);
    nb[5].press = sb[4].side.dz ? '0 : sum[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[BackStages-1:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 1; k <= BackStages; k++) begin
        sb[k] <= nb[k];
      end
    end
  end

  assign out_valid      = vld[BackStages];
  assign temp_centi     = sb[BackStages].side.tc;
  assign press_q24_8    = sb[BackStages].press;
  assign hum_q22_10     = sb[BackStages].side.hum;
  assign press_div_zero = sb[BackStages].side.dz;

endmodule
`default_nettype wire

// ===== rtl/env_sensor_compensation.sv =====
`default_nettype none
// Integer compensation of one raw temperature / pressure / humidity reading
// set per beat. Trim words are loaded through cfg_we/cfg_index/cfg_data
// (index 0..5: temp_trim, press_trim_a, press_trim_b, press_trim_c,
// hum_trim_a, hum_trim_b; other indexes ignored) and must only change while
// no beat is in flight. The block takes one beat every cycle while the result
// side does not stall and returns one result beat per input beat, in order,
// through 11 front stages (temperature, humidity, pressure terms), 66 stages
// of the radix-2 signed divider that forms the pressure quotient, and 5
// back stages. A stall on the result side freezes the whole pipeline, so
// sensor.ready follows result.ready whenever a result is waiting.
module env_sensor_compensation import envc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  envc_in_if.sink          sensor,
  envc_out_if.source       result,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  trim_t  trim;
  logic   adv;
  logic   front_valid;
  front_t front_data;
  logic   div_valid;
  quot_t  div_data;

  // trim registers
  always_ff @(posedge clk) begin
    if (rst) begin
      trim <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_TEMP_TRIM:    trim.temp_trim    <= cfg_data[47:0];
        REG_PRESS_TRIM_A: trim.press_trim_a <= cfg_data;
        REG_PRESS_TRIM_B: trim.press_trim_b <= cfg_data;
        REG_PRESS_TRIM_C: trim.press_trim_c <= cfg_data[15:0];
        REG_HUM_TRIM_A:   trim.hum_trim_a   <= cfg_data[47:0];
        REG_HUM_TRIM_B:   trim.hum_trim_b   <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // global advance: the pipeline moves unless a finished result is held
  assign adv          = !result.valid || result.ready;
  assign sensor.ready = adv;

  envc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (sensor.valid),
    .raw_temp  (sensor.raw_temp),
    .raw_press (sensor.raw_press),
    .raw_hum   (sensor.raw_hum),
    .trim      (trim),
    .out_valid (front_valid),
    .out_data  (front_data)
  );

  envc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (front_valid),
    .in_data   (front_data),
    .out_valid (div_valid),
    .out_data  (div_data)
  );

  envc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .adv            (adv),
    .in_valid       (div_valid),
    .in_data        (div_data),
    .trim           (trim),
    .out_valid      (result.valid),
    .temp_centi     (result.temp_centi),
    .press_q24_8    (result.press_q24_8),
    .hum_q22_10     (result.hum_q22_10),
    .press_div_zero (result.press_div_zero)
  );

endmodule
`default_nettype wire

// ===== rtl/envc_checker.sv =====
`default_nettype none
module envc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic [31:0] temp_centi,
  input wire logic [31:0] press_q24_8,
  input wire logic [16:0] hum_q22_10,
  input wire logic        press_div_zero
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(temp_centi)
      && $stable(press_q24_8) && $stable(hum_q22_10) && $stable(press_div_zero))
    else $error("stalled result changed");

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && press_div_zero |-> press_q24_8 == 32'd0)
    else $error("divide by zero with nonzero pressure");

  a_hum_clamp: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> hum_q22_10 <= 17'd102400)
    else $error("humidity above clamp");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> in_ready)
    else $error("input stalled with no result pending");

endmodule

bind env_sensor_compensation envc_checker u_envc_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (sensor.ready),
  .res_valid      (result.valid),
  .res_ready      (result.ready),
  .temp_centi     (result.temp_centi),
  .press_q24_8    (result.press_q24_8),
  .hum_q22_10     (result.hum_q22_10),
  .press_div_zero (result.press_div_zero)
);
`default_nettype wire
